// ===== design/dda_pkg.sv =====
package dda_pkg;

    // Depth of the segment queue between the setup divider and the pixel stepper.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fill status of the segment queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Setup sequencer states.
    typedef enum logic [2:0] {
        FE_IDLE = 3'b001,
        FE_DIV  = 3'b010,
        FE_PUSH = 3'b100
    } fe_state_t;

endpackage

// ===== design/dda_fifo.sv =====
module dda_fifo
    import dda_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    input  logic         out_pop,
    output logic [W-1:0] out_data,
    output q_stat_t      stat
);

    logic [W-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    // Status and handshake qualification.
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push       = in_valid && !stat.full;
    assign pop        = out_pop && !stat.empty;
    assign out_data   = mem_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== design/dda_front.sv =====
module dda_front
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   end_x,
    input  logic [COORD_BITS-1:0]   end_y,
    output logic                    job_valid,
    input  q_stat_t                 q_stat,
    output logic [COORD_BITS-1:0]   job_start_x,
    output logic [COORD_BITS-1:0]   job_start_y,
    output logic [FRAC_BITS+1:0]    job_step_x,
    output logic [FRAC_BITS+1:0]    job_step_y,
    output logic [COORD_BITS-1:0]   job_steps
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int DVD_W = C + F;
    localparam int CNT_W = $clog2(DVD_W + 1);

    fe_state_t       state_reg;
    fe_state_t       state_next;
    logic [C-1:0]    sx_reg;
    logic [C-1:0]    sy_reg;
    logic            neg_x_reg;
    logic            neg_y_reg;
    logic [C-1:0]    steps_reg;
    logic [DVD_W-1:0] dvd_x_reg;
    logic [DVD_W-1:0] dvd_y_reg;
    logic [C-1:0]    rem_x_reg;
    logic [C-1:0]    rem_y_reg;
    logic [F:0]      q_x_reg;
    logic [F:0]      q_y_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [C:0]      dx;
    logic [C:0]      dy;
    logic [C-1:0]    adx;
    logic [C-1:0]    ady;
    logic [C-1:0]    steps;
    logic [C:0]      trial_x;
    logic [C:0]      trial_y;
    logic            fit_x;
    logic            fit_y;
    logic            accept;

    assign in_ready  = (state_reg == FE_IDLE);
    assign accept    = in_valid && in_ready;
    assign job_valid = (state_reg == FE_PUSH);

    // Deltas, magnitudes and the step count of the incoming segment.
    assign dx    = {1'b0, end_x} - {1'b0, start_x};
    assign dy    = {1'b0, end_y} - {1'b0, start_y};
    assign adx   = dx[C] ? C'(-dx) : dx[C-1:0];
    assign ady   = dy[C] ? C'(-dy) : dy[C-1:0];
    assign steps = (adx > ady) ? adx : ady;

    // One restoring-division step per axis: shift in the next dividend bit.
    assign trial_x = {rem_x_reg, dvd_x_reg[DVD_W-1]};
    assign trial_y = {rem_y_reg, dvd_y_reg[DVD_W-1]};
    assign fit_x   = (trial_x >= {1'b0, steps_reg});
    assign fit_y   = (trial_y >= {1'b0, steps_reg});

    // Signed increments for the queue.
    assign job_start_x = sx_reg;
    assign job_start_y = sy_reg;
    assign job_steps   = steps_reg;
    assign job_step_x  = neg_x_reg ? (F + 2)'(-{1'b0, q_x_reg}) : {1'b0, q_x_reg};
    assign job_step_y  = neg_y_reg ? (F + 2)'(-{1'b0, q_y_reg}) : {1'b0, q_y_reg};

    // Sequencer: accept, divide, hand off to the queue.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE:
            begin
                if (accept)
                begin
                    state_next = (steps == '0) ? FE_PUSH : FE_DIV;
                end
            end
            FE_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg    <= start_x;
            sy_reg    <= start_y;
            neg_x_reg <= dx[C];
            neg_y_reg <= dy[C];
            steps_reg <= steps;
            dvd_x_reg <= {adx, F'(0)};
            dvd_y_reg <= {ady, F'(0)};
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            q_x_reg   <= '0;
            q_y_reg   <= '0;
            cnt_reg   <= CNT_W'(DVD_W);
        end
        else if (state_reg == FE_DIV)
        begin
            dvd_x_reg <= {dvd_x_reg[DVD_W-2:0], 1'b0};
            dvd_y_reg <= {dvd_y_reg[DVD_W-2:0], 1'b0};
            rem_x_reg <= fit_x ? C'(trial_x - {1'b0, steps_reg}) : trial_x[C-1:0];
            rem_y_reg <= fit_y ? C'(trial_y - {1'b0, steps_reg}) : trial_y[C-1:0];
            q_x_reg   <= {q_x_reg[F-1:0], fit_x};
            q_y_reg   <= {q_y_reg[F-1:0], fit_y};
            cnt_reg   <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== design/dda_back.sv =====
module dda_back
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  q_stat_t                 q_stat,
    output logic                    q_pop,
    input  logic [COORD_BITS-1:0]   job_start_x,
    input  logic [COORD_BITS-1:0]   job_start_y,
    input  logic [FRAC_BITS+1:0]    job_step_x,
    input  logic [FRAC_BITS+1:0]    job_step_y,
    input  logic [COORD_BITS-1:0]   job_steps,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COORD_BITS-1:0]   pixel_x,
    output logic [COORD_BITS-1:0]   pixel_y,
    output logic                    last_pixel
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int ACC_W = C + F;

    logic             busy_reg;
    logic [ACC_W-1:0] acc_x_reg;
    logic [ACC_W-1:0] acc_y_reg;
    logic [F+1:0]     step_x_reg;
    logic [F+1:0]     step_y_reg;
    logic [C-1:0]     left_reg;
    logic             valid_reg;
    logic [C-1:0]     pix_x_reg;
    logic [C-1:0]     pix_y_reg;
    logic             last_reg;
    logic [ACC_W-1:0] acc_x_next;
    logic [ACC_W-1:0] acc_y_next;
    logic             slot_free;
    logic             advance;

    assign out_valid  = valid_reg;
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_reg;

    // The output register takes a new pixel when empty or being drained.
    assign slot_free = !valid_reg || out_ready;
    assign q_pop     = !busy_reg && !q_stat.empty && slot_free;
    assign advance   = busy_reg && slot_free;

    // The accumulators carry a bias of one half, so the integer field is the rounded value.
    assign acc_x_next = acc_x_reg + {{(ACC_W - F - 2){step_x_reg[F+1]}}, step_x_reg};
    assign acc_y_next = acc_y_reg + {{(ACC_W - F - 2){step_y_reg[F+1]}}, step_y_reg};

    // Control: segment busy flag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= (job_steps != '0);
            end
            else if (advance && (left_reg == C'(1)))
            begin
                busy_reg <= 1'b0;
            end
            if (q_pop || advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Stepping datapath and output payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            acc_x_reg  <= {job_start_x, 1'b1, (F - 1)'(0)};
            acc_y_reg  <= {job_start_y, 1'b1, (F - 1)'(0)};
            step_x_reg <= job_step_x;
            step_y_reg <= job_step_y;
            left_reg   <= job_steps;
            pix_x_reg  <= job_start_x;
            pix_y_reg  <= job_start_y;
            last_reg   <= (job_steps == '0);
        end
        else if (advance)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            left_reg  <= left_reg - 1'b1;
            pix_x_reg <= acc_x_next[ACC_W-1:F];
            pix_y_reg <= acc_y_next[ACC_W-1:F];
            last_reg  <= (left_reg == C'(1));
        end
    end

endmodule

// ===== design/dda_line_rasterizer.sv =====
// DDA line rasterizer. Each input word is one segment (start and end point); the block
// emits the start pixel and then one pixel per step, where the step count is the larger of
// the absolute x and y deltas, and flags the final pixel with tlast. A setup unit computes
// both fixed-point increments with a radix-2 restoring divider that retires one quotient bit
// per cycle; a segment whose points are equal skips the divider. A two-entry queue feeds
// the pixel stepper, which emits one pixel per cycle while m_tready is high and a segment
// is queued, steps + 1 pixels per segment (up to 64 at the default sizes). Setup of the
// next segment overlaps the stepping of the current one; setup waits while the queue is full.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y, zero fill.
    input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0: pixel_x, pixel_y, zero fill.
    output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int OUT_W = ((2 * C + 7) / 8) * 8;
    localparam int JOB_W = 3 * C + 2 * (F + 2);

    logic [C-1:0]     fe_sx;
    logic [C-1:0]     fe_sy;
    logic [F+1:0]     fe_step_x;
    logic [F+1:0]     fe_step_y;
    logic [C-1:0]     fe_steps;
    logic             fe_valid;
    q_stat_t          q_stat;
    logic             q_pop;
    logic [JOB_W-1:0] q_in;
    logic [JOB_W-1:0] q_out;
    logic [C-1:0]     pixel_x;
    logic [C-1:0]     pixel_y;

    // Segment setup: deltas, step count and increments.
    dda_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .start_x     (s_tdata[C-1:0]),
        .start_y     (s_tdata[2*C-1:C]),
        .end_x       (s_tdata[3*C-1:2*C]),
        .end_y       (s_tdata[4*C-1:3*C]),
        .job_valid   (fe_valid),
        .q_stat      (q_stat),
        .job_start_x (fe_sx),
        .job_start_y (fe_sy),
        .job_step_x  (fe_step_x),
        .job_step_y  (fe_step_y),
        .job_steps   (fe_steps)
    );

    // Queue of prepared segments.
    assign q_in = {fe_steps, fe_step_y, fe_step_x, fe_sy, fe_sx};

    dda_fifo #(
        .W (JOB_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fe_valid),
        .in_data  (q_in),
        .out_pop  (q_pop),
        .out_data (q_out),
        .stat     (q_stat)
    );

    // Pixel stepper with output register.
    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .job_start_x (q_out[C-1:0]),
        .job_start_y (q_out[2*C-1:C]),
        .job_step_x  (q_out[2*C+F+1:2*C]),
        .job_step_y  (q_out[2*C+2*F+3:2*C+F+2]),
        .job_steps   (q_out[JOB_W-1:JOB_W-C]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = OUT_W'({pixel_y, pixel_x});

    // The setup unit is not ready in the cycle after it takes a segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("setup unit accepted two segments back to back");

    // The queue cannot report full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // A segment is popped only when the output register can take its start pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!m_tvalid || m_tready))
        else $error("segment popped while output word stalled");

    // A pop always produces an output word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_tvalid)
        else $error("start pixel missing after pop");

endmodule

// ===== tb/sv/tb_dda_line_rasterizer.sv =====
`timescale 1ns / 100ps

module tb_dda_line_rasterizer;

    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 16;
    localparam int S_WIDTH    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_WIDTH    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

    localparam int RANDOM_SEGMENTS = 300;
    localparam int DIRECTED_COUNT  = 23;

    typedef logic [COORD_BITS-1:0] coord_t;

    // One segment as it travels in s_tdata.
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } segment_t;

    // One pixel as it travels on the output side.
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    // Directed stimulus row; known_count > 0 means the pixels are typed in.
    typedef struct packed {
        segment_t   seg;
        logic [1:0] known_count;
        pixel_t     pix0;
        pixel_t     pix1;
    } directed_row_t;

    localparam pixel_t NO_PIX = '0;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Equal points give only the start pixel, flagged as last.
        '{'{0, 0, 0, 0},     2'd1, '{0, 0, 1},    NO_PIX},
        '{'{63, 63, 63, 63}, 2'd1, '{63, 63, 1},  NO_PIX},
        '{'{42, 21, 42, 21}, 2'd1, '{42, 21, 1},  NO_PIX},
        // Single steps in each direction.
        '{'{0, 0, 1, 0},     2'd2, '{0, 0, 0},    '{1, 0, 1}},
        '{'{63, 63, 62, 63}, 2'd2, '{63, 63, 0},  '{62, 63, 1}},
        '{'{10, 20, 11, 21}, 2'd2, '{10, 20, 0},  '{11, 21, 1}},
        '{'{21, 42, 20, 41}, 2'd2, '{21, 42, 0},  '{20, 41, 1}},
        // Full-length diagonals and axis lines, both directions.
        '{'{0, 0, 63, 63},   2'd0, NO_PIX, NO_PIX},
        '{'{63, 63, 0, 0},   2'd0, NO_PIX, NO_PIX},
        '{'{0, 63, 63, 0},   2'd0, NO_PIX, NO_PIX},
        '{'{63, 0, 0, 63},   2'd0, NO_PIX, NO_PIX},
        '{'{0, 0, 63, 0},    2'd0, NO_PIX, NO_PIX},
        '{'{0, 0, 0, 63},    2'd0, NO_PIX, NO_PIX},
        '{'{63, 0, 0, 0},    2'd0, NO_PIX, NO_PIX},
        '{'{0, 63, 0, 0},    2'd0, NO_PIX, NO_PIX},
        // Shallow and steep slopes.
        '{'{0, 0, 63, 1},    2'd0, NO_PIX, NO_PIX},
        '{'{0, 0, 1, 63},    2'd0, NO_PIX, NO_PIX},
        // Increment of exactly one half (rounding ties go up), then assorted slopes.
        '{'{0, 0, 2, 1},     2'd0, NO_PIX, NO_PIX},
        '{'{2, 1, 0, 0},     2'd0, NO_PIX, NO_PIX},
        '{'{5, 10, 40, 27},  2'd0, NO_PIX, NO_PIX},
        '{'{42, 21, 21, 42}, 2'd0, NO_PIX, NO_PIX},
        '{'{21, 42, 42, 21}, 2'd0, NO_PIX, NO_PIX},
        '{'{0, 0, 63, 62},   2'd0, NO_PIX, NO_PIX}
    };

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [S_WIDTH-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [M_WIDTH-1:0] m_tdata;
    logic               m_tlast;

    pixel_t pending_pixels [$];
    int     mismatch_count = 0;
    bit     sender_steady  = 1'b0;

    // Receiver bookkeeping, owned by the receiver process.
    int     delivered     = 0;
    int     hold_left     = 0;
    bit     hold_done     = 1'b0;

    dda_line_rasterizer #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Generous bound on the whole run.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < 40)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Per-axis step: delta scaled by the fraction, divided by the span, toward zero.
    function automatic longint axis_increment(longint delta, longint span);
        longint mag;
        longint quot;
        mag  = (delta < 0) ? -delta : delta;
        quot = (mag << FRAC_BITS) / span;
        return (delta < 0) ? -quot : quot;
    endfunction

    // floor(acc + 1/2) in grid units, kept to the coordinate width.
    function automatic coord_t round_half_up(longint acc);
        longint v;
        v = acc + (longint'(1) <<< (FRAC_BITS - 1));
        v = v >>> FRAC_BITS;
        return v[COORD_BITS-1:0];
    endfunction

    // Walk the segment as the DDA does and queue every pixel it should emit.
    task automatic rasterize_segment(segment_t seg);
        longint dx;
        longint dy;
        longint adx;
        longint ady;
        longint span;
        longint acc_x;
        longint acc_y;
        longint inc_x;
        longint inc_y;
        longint k;
        dx    = longint'(seg.ex) - longint'(seg.sx);
        dy    = longint'(seg.ey) - longint'(seg.sy);
        adx   = (dx < 0) ? -dx : dx;
        ady   = (dy < 0) ? -dy : dy;
        span  = (adx > ady) ? adx : ady;
        acc_x = longint'(seg.sx) <<< FRAC_BITS;
        acc_y = longint'(seg.sy) <<< FRAC_BITS;
        inc_x = 0;
        inc_y = 0;
        if (span != 0)
        begin
            inc_x = axis_increment(dx, span);
            inc_y = axis_increment(dy, span);
        end
        pending_pixels.push_back(pixel_t'{seg.sx, seg.sy, span == 0});
        for (k = span - 1; k >= 0; k--)
        begin
            acc_x += inc_x;
            acc_y += inc_y;
            pending_pixels.push_back(pixel_t'{round_half_up(acc_x), round_half_up(acc_y),
                k == 0});
        end
    endtask

    // A coordinate a few units from c, clipped to the grid.
    function automatic coord_t nearby(coord_t c);
        int v;
        v = int'(c) + $urandom_range(0, 6) - 3;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return coord_t'(v);
    endfunction

    // Mostly free segments, then short ones, axis lines and single points.
    function automatic segment_t random_segment();
        segment_t seg;
        int       pick;
        seg.sx = coord_t'($urandom);
        seg.sy = coord_t'($urandom);
        seg.ex = coord_t'($urandom);
        seg.ey = coord_t'($urandom);
        pick   = $urandom_range(99);
        if (pick >= 60 && pick < 85)
        begin
            seg.ex = nearby(seg.sx);
            seg.ey = nearby(seg.sy);
        end
        else if (pick >= 85 && pick < 90)
        begin
            seg.ey = seg.sy;
        end
        else if (pick >= 90 && pick < 95)
        begin
            seg.ex = seg.sx;
        end
        else if (pick >= 95)
        begin
            seg.ex = seg.sx;
            seg.ey = seg.sy;
        end
        return seg;
    endfunction

    // Offer one segment word, with an optional gap, and return once it is taken.
    task automatic send_segment(segment_t seg);
        int gap;
        if (!sender_steady && $urandom_range(99) < 23)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seg.ey, seg.ex, seg.sy, seg.sx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Sender: reset, directed table, then random segments.
    initial
    begin
        segment_t seg;
        int       i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_segment(DIRECTED_ROWS[i].seg);
            if (DIRECTED_ROWS[i].known_count == 2'd0)
            begin
                rasterize_segment(DIRECTED_ROWS[i].seg);
            end
            else
            begin
                pending_pixels.push_back(DIRECTED_ROWS[i].pix0);
                if (DIRECTED_ROWS[i].known_count == 2'd2)
                begin
                    pending_pixels.push_back(DIRECTED_ROWS[i].pix1);
                end
            end
        end

        for (i = 0; i < RANDOM_SEGMENTS; i++)
        begin
            // Let the block run completely dry once before going on.
            if (i == 150)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            sender_steady = (i >= 200 && i < 260);
            seg = random_segment();
            send_segment(seg);
            rasterize_segment(seg);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (150) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off, and a stretch of steady readiness.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                delivered++;
            end
            if (!hold_done && delivered >= 1000)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (delivered >= 3000 && delivered < 3800)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // Compare each accepted pixel word against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel (%0d,%0d) last=%0b with none expected",
                    m_tdata[COORD_BITS-1:0], m_tdata[2*COORD_BITS-1:COORD_BITS], m_tlast));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[COORD_BITS-1:0] !== want.x)
                begin
                    report_mismatch($sformatf("pixel_x %0d, wanted %0d",
                        m_tdata[COORD_BITS-1:0], want.x));
                end
                if (m_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
                begin
                    report_mismatch($sformatf("pixel_y %0d, wanted %0d",
                        m_tdata[2*COORD_BITS-1:COORD_BITS], want.y));
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch($sformatf("last_pixel %0b, wanted %0b at (%0d,%0d)",
                        m_tlast, want.last, want.x, want.y));
                end
            end
        end
    end

endmodule
